// ----- rtl/core/ptb_pkg.sv -----
// ----------------------------------------------------------------------------
// ptb_pkg: shared types and constants of the periodic timer bank
// Item formats, command kinds, sequencer states and control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

  // bank size default and hard limits of the result stream
  localparam int DEF_NUM_TIMERS = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int RES_CNT_W      = 5;
  localparam int ACT_W          = 5;
  localparam int CMP_W          = 7;

  // command kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_ARM    = 2'd1;
  localparam logic [1:0] KIND_DISARM = 2'd2;

  // input transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  timer_index;
    logic [31:0] timeout_value;
    logic [31:0] interval_value;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [3:0] expired_timer;
    logic       last;
  } out_item_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // sequencer to countdown unit
  typedef struct packed {
    logic exec;
    logic flush;
    logic clear;
  } ctl_t;

  // countdown unit write-back to the remaining count store
  typedef struct packed {
    logic        we;
    logic [31:0] value;
  } wb_t;

endpackage

`default_nettype wire

// ----- rtl/core/ptb_store.sv -----
// ----------------------------------------------------------------------------
// ptb_store: timer state memory
// Remaining count and reload interval arrays, one write port each, one shared
// registered read port. Per-entry valid bits make unwritten entries read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_store #(
  parameter int NUM_TIMERS = 16,
  parameter int IDX_W      = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output logic      [31:0]       rd_rem,
  output logic      [31:0]       rd_rel,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire logic              rem_we,
  input  wire logic [31:0]       rem_wdata,
  input  wire logic              rel_we,
  input  wire logic [31:0]       rel_wdata
);

  logic [31:0]           rem_mem [NUM_TIMERS];
  logic [31:0]           rel_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] rem_vld_r;
  logic [NUM_TIMERS-1:0] rel_vld_r;
  logic [31:0]           rem_q_r;
  logic [31:0]           rel_q_r;
  logic                  rem_vq_r;
  logic                  rel_vq_r;

  // memory writes
  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[wr_addr] <= rem_wdata;
    end
    if (rel_we) begin
      rel_mem[wr_addr] <= rel_wdata;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_vld_r <= '0;
      rel_vld_r <= '0;
    end else begin
      if (rem_we) begin
        rem_vld_r[wr_addr] <= 1'b1;
      end
      if (rel_we) begin
        rel_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rem_q_r  <= rem_mem[rd_addr];
      rel_q_r  <= rel_mem[rd_addr];
      rem_vq_r <= rem_vld_r[rd_addr];
      rel_vq_r <= rel_vld_r[rd_addr];
    end
  end

  // never-written entries read as reset value
  assign rd_rem = rem_vq_r ? rem_q_r : 32'd0;
  assign rd_rel = rel_vq_r ? rel_q_r : 32'd0;

endmodule

`default_nettype wire

// ----- rtl/core/ptb_unit.sv -----
// ----------------------------------------------------------------------------
// ptb_unit: shared countdown unit and result stage
// Decrements one timer entry per cycle, detects expiry, and holds back the
// newest expiry by one so the final result of a tick carries the last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_unit #(
  parameter int IDX_W = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ptb_pkg::ctl_t      ctl,
  input  wire logic [IDX_W-1:0]   ex_idx,
  input  wire logic [31:0]        rem,
  input  wire logic [31:0]        rel,
  output ptb_pkg::wb_t            wb,
  output logic                    out_valid,
  output ptb_pkg::out_item_t      out_item
);

  import ptb_pkg::*;

  logic [31:0]          dec;
  logic                 armed;
  logic                 expire;
  logic [IDX_W+3:0]     idx_ext;
  logic [3:0]           idx4;
  logic                 take;
  logic                 pend_vld_r, pend_vld_nxt;
  logic [3:0]           pend_idx_r, pend_idx_nxt;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_vld_r, out_vld_nxt;
  out_item_t            out_item_r, out_item_nxt;

  // decrement and zero compare
  always_comb begin
    dec     = rem - 32'd1;
    armed   = (rem != 32'd0);
    expire  = ctl.exec && armed && (dec == 32'd0);
    idx_ext = {4'b0000, ex_idx};
    idx4    = idx_ext[3:0];
  end

  // write-back: reload on expiry, else store the decremented count
  always_comb begin
    wb.we    = ctl.exec && armed;
    wb.value = (dec == 32'd0) ? rel : dec;
  end

  // result lookahead and capping
  always_comb begin
    take         = expire && (cnt_r < RES_CNT_W'(MAX_RESULTS));
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    cnt_nxt      = cnt_r;
    out_vld_nxt  = 1'b0;
    out_item_nxt = out_item_r;
    if (ctl.clear) begin
      cnt_nxt      = '0;
      pend_vld_nxt = 1'b0;
    end else if (ctl.flush) begin
      if (pend_vld_r) begin
        out_vld_nxt                = 1'b1;
        out_item_nxt.expired_timer = pend_idx_r;
        out_item_nxt.last          = 1'b1;
      end
      pend_vld_nxt = 1'b0;
    end else if (take) begin
      if (pend_vld_r) begin
        out_vld_nxt                = 1'b1;
        out_item_nxt.expired_timer = pend_idx_r;
        out_item_nxt.last          = 1'b0;
      end
      pend_vld_nxt = 1'b1;
      pend_idx_nxt = idx4;
      cnt_nxt      = cnt_r + RES_CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      cnt_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      cnt_r      <= cnt_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- rtl/core/ptb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptb_ctrl: command decode and scan sequencer
// Applies arm and disarm straight from idle; for a tick it walks the timers in use,
// issuing one store read per cycle and steering write-backs to the store.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_ctrl #(
  parameter int NUM_TIMERS = 16,
  parameter int IDX_W      = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire ptb_pkg::in_item_t       in_item,
  input  wire logic [ptb_pkg::ACT_W-1:0] active,
  input  wire ptb_pkg::wb_t            wb,
  output logic                         busy,
  output ptb_pkg::ctl_t                ctl,
  output logic [IDX_W-1:0]             ex_idx,
  output logic                         rd_en,
  output logic [IDX_W-1:0]             rd_addr,
  output logic [IDX_W-1:0]             wr_addr,
  output logic                         rem_we,
  output logic [31:0]                  rem_wdata,
  output logic                         rel_we,
  output logic [31:0]                  rel_wdata
);

  import ptb_pkg::*;

  localparam int SCN_W = IDX_W + 1;

  state_t           state_r, state_nxt;
  logic [SCN_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             ex_vld_r, ex_vld_nxt;
  logic [IDX_W-1:0] ex_idx_r, ex_idx_nxt;
  logic [CMP_W-1:0] act_ext;
  logic [CMP_W-1:0] lim;
  logic [SCN_W-1:0] n_use;
  logic [IDX_W+3:0] tix_ext;
  logic [IDX_W-1:0] tix;
  logic             accept;
  logic             acc_tick;
  logic             acc_arm;
  logic             acc_disarm;
  logic             in_range;
  logic             issue;

  // timers in use and command decode
  always_comb begin
    act_ext    = {{(CMP_W-ACT_W){1'b0}}, active};
    lim        = (act_ext > CMP_W'(NUM_TIMERS)) ? CMP_W'(NUM_TIMERS) : act_ext;
    n_use      = lim[SCN_W-1:0];
    tix_ext    = {{IDX_W{1'b0}}, in_item.timer_index};
    tix        = tix_ext[IDX_W-1:0];
    in_range   = ({3'b000, in_item.timer_index} < lim);
    accept     = start && (state_r == ST_IDLE);
    acc_tick   = accept && (in_item.kind == KIND_TICK) && (n_use != '0);
    acc_arm    = accept && (in_item.kind == KIND_ARM) && in_range;
    acc_disarm = accept && (in_item.kind == KIND_DISARM) && in_range;
    issue      = (state_r == ST_SCAN) && (rd_cnt_r < n_use);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_tick) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue && ex_vld_r) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // scan counters
  always_comb begin
    rd_cnt_nxt = rd_cnt_r;
    if (acc_tick) begin
      rd_cnt_nxt = '0;
    end else if (issue) begin
      rd_cnt_nxt = rd_cnt_r + SCN_W'(1);
    end
    ex_vld_nxt = issue;
    ex_idx_nxt = rd_cnt_r[IDX_W-1:0];
  end

  // outputs
  always_comb begin
    busy      = (state_r != ST_IDLE);
    ctl.exec  = ex_vld_r;
    ctl.flush = (state_r == ST_FLUSH);
    ctl.clear = acc_tick;
    ex_idx    = ex_idx_r;
    rd_en     = issue;
    rd_addr   = rd_cnt_r[IDX_W-1:0];
    if (state_r == ST_IDLE) begin
      wr_addr   = tix;
      rem_we    = acc_arm || acc_disarm;
      rem_wdata = acc_arm ? in_item.timeout_value : 32'd0;
      rel_we    = acc_arm;
    end else begin
      wr_addr   = ex_idx_r;
      rem_we    = wb.we;
      rem_wdata = wb.value;
      rel_we    = 1'b0;
    end
    rel_wdata = in_item.interval_value;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_cnt_r <= '0;
      ex_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      ex_vld_r <= ex_vld_nxt;
    end
  end

  // entry index in flight
  always_ff @(posedge clk) begin
    ex_idx_r <= ex_idx_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/periodic_timer_bank.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_bank: bank of one-shot and periodic countdown timers
//
// Usage:
//   A command is taken when start is high and busy is low. kind selects
//   tick, arm or disarm. Arm loads timeout and interval for one timer,
//   disarm clears its remaining count; both give no result and are
//   ignored for an index outside the timers in use.
//   A tick walks timers 0 .. n-1 (n = min(active_timers, NUM_TIMERS)) through
//   one shared decrement/compare unit, one entry per cycle, fed by the
//   registered read port of the timer memory. busy stays high through the
//   scan and the flush state; a tick with n = 0 finishes at once.
//   Each expiry gives one result transaction: out_valid is high for exactly
//   one cycle with the expiring index. Results come in index order, up to
//   16 per tick; the final one carries last. The receiver cannot stall.
//   cfg_we writes active_timers; write it only while busy is low.
//   Reset (rst_n low, synchronous) disarms every timer, zeroes every
//   interval through per-entry valid bits and clears active_timers.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_bank #(
  parameter int NUM_TIMERS = ptb_pkg::DEF_NUM_TIMERS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire ptb_pkg::in_item_t         in_item,
  output logic                           out_valid,
  output ptb_pkg::out_item_t             out_item,
  input  wire logic                      cfg_we,
  input  wire logic [ptb_pkg::ACT_W-1:0] cfg_wdata
);

  import ptb_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [ACT_W-1:0] active_r;
  ctl_t             ctl;
  wb_t              wb;
  logic [IDX_W-1:0] ex_idx;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      rd_rem;
  logic [31:0]      rd_rel;
  logic [IDX_W-1:0] wr_addr;
  logic             rem_we;
  logic [31:0]      rem_wdata;
  logic             rel_we;
  logic [31:0]      rel_wdata;

  // active timer count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  // command decode and scan sequencer
  ptb_ctrl #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .active    (active_r),
    .wb        (wb),
    .busy      (busy),
    .ctl       (ctl),
    .ex_idx    (ex_idx),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .rem_we    (rem_we),
    .rem_wdata (rem_wdata),
    .rel_we    (rel_we),
    .rel_wdata (rel_wdata)
  );

  // timer state memory
  ptb_store #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_rem    (rd_rem),
    .rd_rel    (rd_rel),
    .wr_addr   (wr_addr),
    .rem_we    (rem_we),
    .rem_wdata (rem_wdata),
    .rel_we    (rel_we),
    .rel_wdata (rel_wdata)
  );

  // shared countdown unit and result stage
  ptb_unit #(
    .IDX_W (IDX_W)
  ) u_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .ex_idx    (ex_idx),
    .rem       (rd_rem),
    .rel       (rd_rel),
    .wb        (wb),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- rtl/core/ptb_checker.sv -----
// ----------------------------------------------------------------------------
// ptb_checker: port-level checks for the periodic timer bank
// Watches command and result transactions on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire ptb_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire ptb_pkg::out_item_t out_item
);

  import ptb_pkg::*;

  // results only come out of a tick in progress
  a_result_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result transaction outside a tick");

  // arm, disarm and unknown kinds never leave the block busy
  a_cmd_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind != KIND_TICK) |=> !busy)
    else $error("arm or disarm left the block busy");

  // nothing follows the last result of a tick
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |=> !out_valid)
    else $error("result transaction after last");

  // a tick gives no result in the cycle after it is taken
  a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind == KIND_TICK) |=> !out_valid)
    else $error("result too early after tick");

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
